// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/rbr_pkg.sv -----
// ----------------------------------------------------------------------------
// Radial bulge remap package
// Types, widths and constants shared by the remap datapath, channels and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rbr_pkg;

   localparam int MaxDim        = 4096;
   localparam int CoordFracBits = 4;

   localparam int DIM_W        = 13;
   localparam int COORD_W      = 12;
   localparam int GAIN_W       = 16;
   localparam int SRC_W        = 20;
   localparam int NORM_FRAC    = 16;
   localparam int QUOT_W       = COORD_W + NORM_FRAC;
   localparam int REM_W        = DIM_W - 1;
   localparam int NORM_W       = NORM_FRAC + 1;
   localparam int SQ_W         = 2 * NORM_FRAC - 1;
   localparam int R2_W         = 2 * NORM_FRAC;
   localparam int Z_W          = 29;
   localparam int ACC_W        = 36;
   localparam int ACC_LO_W     = 16;
   localparam int Q30_SHIFT    = 30;
   localparam int HORNER_STEPS = 6;
   localparam int RoundShift   = 22 - CoordFracBits;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CsrImageWidth  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CsrImageHeight = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CsrBulgeGain   = 2'd2;

   localparam int SrcLow  = -262144;
   localparam int SrcHigh = 327680;

   typedef logic [DIM_W-1:0]          dim_type;
   typedef logic [COORD_W-1:0]        coord_type;
   typedef logic signed [GAIN_W-1:0]  gain_type;
   typedef logic signed [SRC_W-1:0]   src_type;
   typedef logic [QUOT_W-1:0]         quot_type;
   typedef logic [REM_W-1:0]          rem_type;
   typedef logic signed [NORM_W-1:0]  norm_type;
   typedef logic [SQ_W-1:0]           sq_type;
   typedef logic [R2_W-1:0]           r2_type;
   typedef logic [Z_W-1:0]            zarg_type;
   typedef logic signed [ACC_W-1:0]   acc_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      norm_type  u;
      norm_type  v;
      logic      in_radius;
   } pass_type;

   // cos(pi*sqrt(z)) series coefficients c0..c6, Q.30
   localparam acc_type CosCoef [HORNER_STEPS+1] = '{
      36'sd1073741824,
      -36'sd5298703516,
      36'sd4358008962,
      -36'sd1433727481,
      36'sd252684340,
      -36'sd27709939,
      36'sd2071865
   };

   localparam acc_type Q30One = 36'sd1073741824;

endpackage

`default_nettype wire

// ----- hw/rtl/rbr_channels.sv -----
// ----------------------------------------------------------------------------
// Radial bulge remap channels
// Valid/ready channels for destination coordinates and source coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface rbr_req_if;
   import rbr_pkg::*;
   logic      valid;
   logic      ready;
   coord_type dest_x;
   coord_type dest_y;
   modport source (output valid, output dest_x, output dest_y, input ready);
   modport sink   (input valid, input dest_x, input dest_y, output ready);
endinterface

interface rbr_rsp_if;
   import rbr_pkg::*;
   logic    valid;
   logic    ready;
   src_type source_x;
   src_type source_y;
   modport source (output valid, output source_x, output source_y, input ready);
   modport sink   (input valid, input source_x, input source_y, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/radial_bulge_remap_coordinates.sv -----
// ----------------------------------------------------------------------------
// Radial bulge remap coordinate generator
// Maps each destination pixel to the source coordinate of a bulge warp.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one destination pixel (dest_x, dest_y) per beat; rsp_bus
//   returns one source coordinate (source_x, source_y) per beat, signed fixed
//   point with 4 fraction bits, in request order.
//   csr_we/csr_index/csr_wdata write image_width (0), image_height (1) and
//   bulge_gain (2); other indexes are dropped. Write only while the pipe is
//   empty.
//   Throughput: one beat per cycle while the receiver does not stall. The pipe
//   depth comes from the two restoring dividers (one quotient bit per stage,
//   28 stages) and the six Horner steps of the cosine series, each split into
//   a partial-product stage and an accumulate stage.
//   Reset clears all valid bits and loads 64 x 64 with gain 0.5.
//   When the receiver stalls, the whole pipe holds in place; req_bus.ready
//   stays high while the output register is empty or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module radial_bulge_remap_coordinates (
   input  logic                                 clock,
   input  logic                                 reset,
   rbr_req_if.sink                              req_bus,
   rbr_rsp_if.source                            rsp_bus,
   input  logic                                 csr_we,
   input  logic [rbr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [rbr_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import rbr_pkg::*;

   localparam int NStages  = QUOT_W + 2 + 2 * HORNER_STEPS + 6;
   localparam int PH_W     = ACC_W - ACC_LO_W + Z_W + 1;
   localparam int PL_W     = ACC_LO_W + 1 + Z_W + 1;
   localparam int SUM_W    = Q30_SHIFT + ACC_W;
   localparam int COS_W    = 32;
   localparam int GAIN_FRAC = 12;
   localparam int KC_W     = GAIN_W + COS_W;
   localparam int US_W     = NORM_W + ACC_W;
   localparam int T_SHIFT  = 24;
   localparam int T_W      = US_W - T_SHIFT;
   localparam int PX_W     = DIM_W + 1 + T_W;
   localparam int RX_W     = PX_W - RoundShift;

   localparam quot_type             NormOne  = quot_type'(1 << NORM_FRAC);
   localparam logic [NORM_W-1:0]    NormHalf = NORM_W'(1 << (NORM_FRAC - 1));
   localparam r2_type               InsideMax = r2_type'(1 << (2 * NORM_FRAC - 2));
   localparam logic [T_W-1:0]       THalf    = T_W'(1 << (T_SHIFT - 3));
   localparam logic [PX_W-1:0]      PxRound  = PX_W'(1 << (RoundShift - 1));
   localparam logic signed [RX_W-1:0] RxLow  = RX_W'(SrcLow);
   localparam logic signed [RX_W-1:0] RxHigh = RX_W'(SrcHigh);

   // ---------------------------------------------------------------------
   // Configuration registers; sizes are clamped to [1, MaxDim] on write
   // ---------------------------------------------------------------------
   dim_type  width_ff, height_ff;
   gain_type gain_ff;
   dim_type  wdata_dim, dim_in;

   always_comb begin
      wdata_dim = csr_wdata[DIM_W-1:0];
      if (wdata_dim == '0) begin
         dim_in = dim_type'(1);
      end else if (wdata_dim > dim_type'(MaxDim)) begin
         dim_in = dim_type'(MaxDim);
      end else begin
         dim_in = wdata_dim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= dim_type'(64);
         height_ff <= dim_type'(64);
         gain_ff   <= gain_type'(2048);
      end else if (csr_we) begin
         case (csr_index)
            CsrImageWidth:  width_ff  <= dim_in;
            CsrImageHeight: height_ff <= dim_in;
            CsrBulgeGain:   gain_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Pipe control: every stage advances together unless the output beat
   // waits on the receiver
   // ---------------------------------------------------------------------
   logic [NStages-1:0] vld_ff;
   logic               adv;

   assign adv           = !vld_ff[NStages-1] || rsp_bus.ready;
   assign req_bus.ready = adv;
   assign rsp_bus.valid = vld_ff[NStages-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NStages-2:0], req_bus.valid};
      end
   end

   // ---------------------------------------------------------------------
   // Restoring dividers: (x << 16) / w and (y << 16) / h, one quotient bit
   // per stage, MSB first. The low 16 dividend bits are zero.
   // ---------------------------------------------------------------------
   coord_type dx_ff [QUOT_W];
   coord_type dy_ff [QUOT_W];
   rem_type   remx_ff [QUOT_W];
   rem_type   remy_ff [QUOT_W];
   quot_type  qx_ff [QUOT_W];
   quot_type  qy_ff [QUOT_W];

   for (genvar j = 0; j < QUOT_W; j++) begin : g_div
      coord_type         x_src, y_src;
      rem_type           remx_src, remy_src;
      quot_type          qx_src, qy_src;
      logic              bit_x, bit_y;
      logic [REM_W:0]    trial_x, trial_y;
      logic              ge_x, ge_y;
      rem_type           remx_in, remy_in;
      quot_type          qx_in, qy_in;

      if (j == 0) begin : g_head
         assign x_src    = req_bus.dest_x;
         assign y_src    = req_bus.dest_y;
         assign remx_src = '0;
         assign remy_src = '0;
         assign qx_src   = '0;
         assign qy_src   = '0;
      end else begin : g_body
         assign x_src    = dx_ff[j-1];
         assign y_src    = dy_ff[j-1];
         assign remx_src = remx_ff[j-1];
         assign remy_src = remy_ff[j-1];
         assign qx_src   = qx_ff[j-1];
         assign qy_src   = qy_ff[j-1];
      end

      if (j < COORD_W) begin : g_coord_bit
         assign bit_x = x_src[COORD_W-1-j];
         assign bit_y = y_src[COORD_W-1-j];
      end else begin : g_zero_bit
         assign bit_x = 1'b0;
         assign bit_y = 1'b0;
      end

      assign trial_x = {remx_src, bit_x};
      assign trial_y = {remy_src, bit_y};
      assign ge_x    = trial_x >= width_ff;
      assign ge_y    = trial_y >= height_ff;
      assign remx_in = ge_x ? REM_W'(trial_x - width_ff) : trial_x[REM_W-1:0];
      assign remy_in = ge_y ? REM_W'(trial_y - height_ff) : trial_y[REM_W-1:0];
      assign qx_in   = {qx_src[QUOT_W-2:0], ge_x};
      assign qy_in   = {qy_src[QUOT_W-2:0], ge_y};

      always_ff @(posedge clock) begin
         if (adv) begin
            dx_ff[j]   <= x_src;
            dy_ff[j]   <= y_src;
            remx_ff[j] <= remx_in;
            remy_ff[j] <= remy_in;
            qx_ff[j]   <= qx_in;
            qy_ff[j]   <= qy_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Normalize and square: u = q - 0.5 in Q.16. A quotient above 1.0 puts
   // the pixel outside the radius, so the square never needs more than
   // 17 bits per operand.
   // ---------------------------------------------------------------------
   norm_type                     u_in, v_in;
   logic signed [2*NORM_W-1:0]   uu_full, vv_full;
   logic                         far_in;
   pass_type                     sq_pass_in, sq_pass_ff;
   logic                         far_ff;
   sq_type                       uu_ff, vv_ff;

   always_comb begin
      u_in    = qx_ff[QUOT_W-1][NORM_W-1:0] - NormHalf;
      v_in    = qy_ff[QUOT_W-1][NORM_W-1:0] - NormHalf;
      far_in  = (qx_ff[QUOT_W-1] > NormOne) || (qy_ff[QUOT_W-1] > NormOne);
      uu_full = u_in * u_in;
      vv_full = v_in * v_in;
      sq_pass_in = '{x: dx_ff[QUOT_W-1], y: dy_ff[QUOT_W-1], u: u_in, v: v_in,
                     in_radius: 1'b0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_pass_ff <= sq_pass_in;
         far_ff     <= far_in;
         uu_ff      <= uu_full[SQ_W-1:0];
         vv_ff      <= vv_full[SQ_W-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Radius test and series argument z = r^2 / 4 (Q.30)
   // ---------------------------------------------------------------------
   r2_type   r2;
   pass_type r2_pass_in, r2_pass_ff;
   zarg_type z_ff;

   always_comb begin
      r2 = r2_type'(uu_ff) + r2_type'(vv_ff);
      r2_pass_in           = sq_pass_ff;
      r2_pass_in.in_radius = !far_ff && (r2 <= InsideMax);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r2_pass_ff <= r2_pass_in;
         z_ff       <= r2[Z_W+1:2];
      end
   end

   // ---------------------------------------------------------------------
   // Horner evaluation of cos(pi*sqrt(z)): each step is a partial-product
   // stage (acc split into high and low halves) and an accumulate stage.
   // ---------------------------------------------------------------------
   pass_type                 ha_pass_ff [HORNER_STEPS];
   zarg_type                 ha_z_ff    [HORNER_STEPS];
   logic signed [PH_W-1:0]   ph_ff      [HORNER_STEPS];
   logic signed [PL_W-1:0]   pl_ff      [HORNER_STEPS];
   pass_type                 hb_pass_ff [HORNER_STEPS];
   zarg_type                 hb_z_ff    [HORNER_STEPS];
   acc_type                  acc_ff     [HORNER_STEPS];

   for (genvar i = 0; i < HORNER_STEPS; i++) begin : g_horner
      acc_type                        acc_src;
      zarg_type                       z_src;
      pass_type                       pass_src;
      logic signed [Z_W:0]            z_s;
      logic signed [ACC_W-ACC_LO_W-1:0] acc_hi;
      logic signed [ACC_LO_W:0]       acc_lo;
      logic signed [PH_W-1:0]         ph_in;
      logic signed [PL_W-1:0]         pl_in;
      logic signed [SUM_W-1:0]        sum_in;
      acc_type                        acc_in;

      if (i == 0) begin : g_first
         assign acc_src  = CosCoef[HORNER_STEPS];
         assign z_src    = z_ff;
         assign pass_src = r2_pass_ff;
      end else begin : g_next
         assign acc_src  = acc_ff[i-1];
         assign z_src    = hb_z_ff[i-1];
         assign pass_src = hb_pass_ff[i-1];
      end

      assign z_s    = {1'b0, z_src};
      assign acc_hi = acc_src[ACC_W-1:ACC_LO_W];
      assign acc_lo = {1'b0, acc_src[ACC_LO_W-1:0]};
      assign ph_in  = acc_hi * z_s;
      assign pl_in  = acc_lo * z_s;

      // floor(acc * z / 2^30) is the top of the recombined product
      assign sum_in = (SUM_W'(ph_ff[i]) <<< ACC_LO_W) + SUM_W'(pl_ff[i]);
      assign acc_in = CosCoef[HORNER_STEPS-1-i] + sum_in[Q30_SHIFT +: ACC_W];

      always_ff @(posedge clock) begin
         if (adv) begin
            ha_pass_ff[i] <= pass_src;
            ha_z_ff[i]    <= z_src;
            ph_ff[i]      <= ph_in;
            pl_ff[i]      <= pl_in;
            hb_pass_ff[i] <= ha_pass_ff[i];
            hb_z_ff[i]    <= ha_z_ff[i];
            acc_ff[i]     <= acc_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Scale factor s = 1 - k*cos (Q.30), then u*s and v*s
   // ---------------------------------------------------------------------
   logic signed [COS_W-1:0]  cos_val;
   logic signed [KC_W-1:0]   kc_in, kc_ff;
   pass_type                 kc_pass_ff, s_pass_ff, us_pass_ff, t_pass_ff, px_pass_ff;
   acc_type                  s_in, s_ff;
   logic signed [US_W-1:0]   us_in, vs_in, us_ff, vs_ff;
   logic signed [T_W-1:0]    tx_in, ty_in, tx_ff, ty_ff;
   logic signed [PX_W-1:0]   px_in, py_in, px_ff, py_ff;

   always_comb begin
      cos_val = acc_ff[HORNER_STEPS-1][COS_W-1:0];
      kc_in   = gain_ff * cos_val;
      s_in    = Q30One - kc_ff[KC_W-1:GAIN_FRAC];
      us_in   = s_pass_ff.u * s_ff;
      vs_in   = s_pass_ff.v * s_ff;
      // t = u*s + 0.5 in Q.22
      tx_in   = us_ff[US_W-1:T_SHIFT] + THalf;
      ty_in   = vs_ff[US_W-1:T_SHIFT] + THalf;
      px_in   = $signed({1'b0, width_ff}) * tx_ff;
      py_in   = $signed({1'b0, height_ff}) * ty_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kc_pass_ff <= hb_pass_ff[HORNER_STEPS-1];
         kc_ff      <= kc_in;
         s_pass_ff  <= kc_pass_ff;
         s_ff       <= s_in;
         us_pass_ff <= s_pass_ff;
         us_ff      <= us_in;
         vs_ff      <= vs_in;
         t_pass_ff  <= us_pass_ff;
         tx_ff      <= tx_in;
         ty_ff      <= ty_in;
         px_pass_ff <= t_pass_ff;
         px_ff      <= px_in;
         py_ff      <= py_in;
      end
   end

   // ---------------------------------------------------------------------
   // Round to pixels, saturate, and pick the pass-through outside the radius
   // ---------------------------------------------------------------------
   logic [PX_W-1:0]          rndx, rndy;
   logic signed [RX_W-1:0]   rx, ry, rx_sat, ry_sat;
   src_type                  out_x_in, out_y_in, out_x_ff, out_y_ff;

   always_comb begin
      rndx = px_ff + PxRound;
      rndy = py_ff + PxRound;
      rx   = rndx[PX_W-1:RoundShift];
      ry   = rndy[PX_W-1:RoundShift];

      if (rx < RxLow) begin
         rx_sat = RxLow;
      end else if (rx > RxHigh) begin
         rx_sat = RxHigh;
      end else begin
         rx_sat = rx;
      end

      if (ry < RxLow) begin
         ry_sat = RxLow;
      end else if (ry > RxHigh) begin
         ry_sat = RxHigh;
      end else begin
         ry_sat = ry;
      end

      if (px_pass_ff.in_radius) begin
         out_x_in = SRC_W'(rx_sat);
         out_y_in = SRC_W'(ry_sat);
      end else begin
         out_x_in = SRC_W'(px_pass_ff.x) << CoordFracBits;
         out_y_in = SRC_W'(px_pass_ff.y) << CoordFracBits;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
      end
   end

   assign rsp_bus.source_x = out_x_ff;
   assign rsp_bus.source_y = out_y_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/rbr_checker.sv -----
// ----------------------------------------------------------------------------
// Radial bulge remap port checker
// Watches the top-level ports for stall behavior and output range.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rbr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rbr_pkg::src_type source_x,
   input rbr_pkg::src_type source_y
);
   import rbr_pkg::*;

   localparam src_type Low  = SRC_W'(SrcLow);
   localparam src_type High = SRC_W'(SrcHigh);

   logic stalled;
   assign stalled = rsp_valid && !rsp_ready;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid, "response dropped while stalled")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, stalled, $stable(source_x) && $stable(source_y), "response changed while stalled")
   `ASSERT_IMPLIES(a_req_open, clock, reset, !rsp_valid, req_ready, "request blocked with empty output")
   `ASSERT_IMPLIES(a_x_range, clock, reset, rsp_valid, (source_x >= Low) && (source_x <= High), "source_x out of range")
   `ASSERT_IMPLIES(a_y_range, clock, reset, rsp_valid, (source_y >= Low) && (source_y <= High), "source_y out of range")

endmodule

bind radial_bulge_remap_coordinates rbr_checker u_rbr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .source_x  (rsp_bus.source_x),
   .source_y  (rsp_bus.source_y)
);

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Radial bulge remap testbench
// Drives destination pixels through the remap pipe under several region sizes
// and gains, predicts every source coordinate in exact integer arithmetic and
// compares each returned beat, with random idling on both channels.
// ----------------------------------------------------------------------------

// Predicts source coordinates and holds them until the pipe returns them.
class remap_scoreboard;
   rbr_pkg::dim_type  width_reg;
   rbr_pkg::dim_type  height_reg;
   rbr_pkg::gain_type gain_reg;
   rbr_pkg::src_type  expected_x[$];
   rbr_pkg::src_type  expected_y[$];
   int                errors;

   function new();
      width_reg  = 13'd64;
      height_reg = 13'd64;
      gain_reg   = 16'sd2048;
      errors     = 0;
   endfunction

   function longint clamp_dim(rbr_pkg::dim_type d);
      if (d == 0) return 1;
      if (d > rbr_pkg::MaxDim) return rbr_pkg::MaxDim;
      return longint'(d);
   endfunction

   // cos(pi*sqrt(z)) in Q.30 by Horner steps with floor after each product
   function longint cos_pi_root(longint z);
      longint acc;
      acc = longint'(rbr_pkg::CosCoef[6]);
      for (int n = 5; n >= 0; n--)
         acc = longint'(rbr_pkg::CosCoef[n]) + ((acc * z) >>> 30);
      return acc;
   endfunction

   // scale a normalized offset, move back to pixels and saturate
   function rbr_pkg::src_type to_pixels(longint u, longint s, longint dim);
      longint t;
      longint r;
      t = ((u * s) >>> 24) + (longint'(1) << 21);
      r = (dim * t + (longint'(1) << (rbr_pkg::RoundShift - 1))) >>> rbr_pkg::RoundShift;
      if (r < rbr_pkg::SrcLow)  r = rbr_pkg::SrcLow;
      if (r > rbr_pkg::SrcHigh) r = rbr_pkg::SrcHigh;
      return rbr_pkg::src_type'(r);
   endfunction

   function void note_request(rbr_pkg::coord_type x, rbr_pkg::coord_type y);
      longint w, h, k, u, v, r2, c, s;
      w  = clamp_dim(width_reg);
      h  = clamp_dim(height_reg);
      k  = longint'(gain_reg);
      u  = (longint'(x) << 16) / w - 32768;
      v  = (longint'(y) << 16) / h - 32768;
      r2 = u * u + v * v;
      if (r2 > (longint'(1) << 30)) begin
         expected_x.push_back(rbr_pkg::src_type'(longint'(x) << rbr_pkg::CoordFracBits));
         expected_y.push_back(rbr_pkg::src_type'(longint'(y) << rbr_pkg::CoordFracBits));
      end else begin
         c = cos_pi_root(r2 >> 2);
         s = (longint'(1) << 30) - ((k * c) >>> 12);
         expected_x.push_back(to_pixels(u, s, w));
         expected_y.push_back(to_pixels(v, s, h));
      end
   endfunction

   function void check_response(rbr_pkg::src_type sx, rbr_pkg::src_type sy);
      rbr_pkg::src_type ex, ey;
      if (expected_x.size() == 0) begin
         $error("unexpected response beat source_x=%0d source_y=%0d", sx, sy);
         errors++;
         return;
      end
      ex = expected_x.pop_front();
      ey = expected_y.pop_front();
      if (sx !== ex) begin
         $error("source_x expected %0d actual %0d", ex, sx);
         errors++;
      end
      if (sy !== ey) begin
         $error("source_y expected %0d actual %0d", ey, sy);
         errors++;
      end
   endfunction
endclass

module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rbr_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int PIPE_LATENCY = 48;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CsrImageWidth;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   rbr_req_if req ();
   rbr_rsp_if rsp ();

   remap_scoreboard board = new();

   int  cycles    = 0;
   bit  hold_off  = 1'b0;   // ask the receiver for one long stall
   bit  no_idle   = 1'b0;   // burst stretches with no sender gaps
   int  sent      = 0;

   radial_bulge_remap_coordinates DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req),
      .rsp_bus   (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   initial begin
      req.valid  = 1'b0;
      req.dest_x = '0;
      req.dest_y = '0;
      rsp.ready  = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // fail the run if the pipe never drains
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // check every response beat against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         board.check_response(rsp.source_x, rsp.source_y);
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp.ready = 1'b0;
            repeat (300) @(negedge clock);
            hold_off = 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            n = pick_gap();
            rsp.ready = (n == 0);
            repeat (n > 0 ? n : 1) @(negedge clock);
         end else begin
            rsp.ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   // offer one beat after a random gap and hold it until accepted
   task automatic send_pixel(coord_type x, coord_type y);
      int gap;
      gap = no_idle ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req.valid = 1'b0;
      end
      @(negedge clock);
      req.valid  = 1'b1;
      req.dest_x = x;
      req.dest_y = y;
      do @(posedge clock); while (!req.ready);
      board.note_request(x, y);
      sent++;
      if (sent % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
   endtask

   // drop valid, wait for every prediction to come back, then let the pipe settle
   task automatic drain();
      @(negedge clock);
      req.valid = 1'b0;
      while (board.expected_x.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 12) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (index)
         CsrImageWidth:  board.width_reg  = dim_type'(value);
         CsrImageHeight: board.height_reg = dim_type'(value);
         CsrBulgeGain:   board.gain_reg   = gain_type'(value);
         default: ;
      endcase
   endtask

   task automatic configure(int w, int h, int k);
      write_reg(CsrImageWidth, CSR_DATA_W'(w));
      write_reg(CsrImageHeight, CSR_DATA_W'(h));
      write_reg(CsrBulgeGain, CSR_DATA_W'(k));
   endtask

   // random pixels, mostly inside the region and often near its middle
   task automatic random_pixels(int count);
      int w, h, r;
      coord_type x, y;
      w = int'(board.clamp_dim(board.width_reg));
      h = int'(board.clamp_dim(board.height_reg));
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 9);
         if (r < 6) begin
            x = $urandom_range(0, w - 1);
            y = $urandom_range(0, h - 1);
         end else if (r < 8) begin
            x = $urandom_range(w / 4, (3 * w) / 4);
            y = $urandom_range(h / 4, (3 * h) / 4);
         end else begin
            x = $urandom_range(0, 4095);
            y = $urandom_range(0, 4095);
         end
         send_pixel(x, y);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: corners, centre, edges of the circle, far out of range
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd32, 12'd32);
      send_pixel(12'd4095, 12'd4095);
      send_pixel(12'd63, 12'd0);
      send_pixel(12'd0, 12'd63);
      send_pixel(12'd32, 12'd0);
      send_pixel(12'd0, 12'd32);
      send_pixel(12'd48, 12'd48);
      send_pixel(12'd31, 12'd33);
      send_pixel(12'd4095, 12'd0);
      send_pixel(12'd2730, 12'd1365);
      send_pixel(12'd64, 12'd64);
      random_pixels(70);

      // fill the pipe while the receiver holds off
      hold_off = 1'b1;
      no_idle  = 1'b1;
      random_pixels(80);
      no_idle  = 1'b0;
      drain();

      // zero size treated as one, strongest negative gain, unknown index ignored
      configure(0, 1, -32768);
      write_reg(2'd3, 16'hFFFF);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'd4095, 12'd4095);
      random_pixels(50);
      drain();

      // oversize width saturates, strongest positive gain
      configure(8191, 100, 32767);
      send_pixel(12'd2048, 12'd50);
      send_pixel(12'd4095, 12'd99);
      random_pixels(80);
      drain();

      // full size, no bulge
      configure(4096, 4096, 0);
      send_pixel(12'd2048, 12'd2048);
      send_pixel(12'd4095, 12'd2048);
      random_pixels(80);
      drain();

      // odd sizes and random gains
      configure(17, 4095, -4096);
      random_pixels(50);
      drain();
      configure($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(0, 65535));
      random_pixels(120);
      drain();

      if (board.expected_x.size() != 0) begin
         $error("%0d predicted beats never returned", board.expected_x.size());
         board.errors++;
      end
      if (board.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
